@@ src/pbpe_pkg.sv @@
// ----------------------------------------------------------------------------
// pbpe_pkg
// Shared constants and the brightness function for the palette builder and pixel encoder.
// ----------------------------------------------------------------------------
package pbpe_pkg;
  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = 8;
  localparam int PAL_W     = 25;
  localparam logic [PAL_W-1:0] RESERVED_MARK = 25'h100_0000;
  localparam logic [12:0] DIST_INIT = 13'h1fff;

  localparam logic [2:0] CMD_SCAN = 3'd0;
  localparam logic [2:0] CMD_FIN  = 3'd1;
  localparam logic [2:0] CMD_ENC  = 3'd2;
  localparam logic [2:0] CMD_READ = 3'd3;
  localparam logic [2:0] CMD_CLR  = 3'd4;

  localparam logic CFG_CHAN = 1'b0;
  localparam logic CFG_TEN  = 1'b1;

  function automatic logic [12:0] brightness(input logic [PAL_W-1:0] c);
    brightness = {3'b0, c[23:16], 2'b0} + ({5'b0, c[15:8]} * 13'd5)
               + ({5'b0, c[7:0]} * 13'd3);
  endfunction
endpackage

@@ src/palette_builder_pixel_encoder_top.sv @@
// ----------------------------------------------------------------------------
// palette_builder_pixel_encoder_top
// Builds an RGB palette from scanned pixels and encodes pixels against it.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake   | Payload
//  in_     | input     | valid/stall | cmd, red, green, blue, alpha, entry_index
//  out_    | output    | valid/stall | byte0..2, byte_count, palette_count, flags
//  cfg_    | input     | valid/ready | index, data
//
// One item is worked on at a time. Scan and encode walk the stored palette
// one entry per cycle through the palette RAM read port. Finalize with a full
// palette and transparency walks all entries to find the darkest one and then
// swaps two entries; with a partly filled palette it moves entry 0 to the end.
// The next beat can be accepted once the block is back in idle after the
// result is loaded.
// No clearing pass is needed after reset: only entries below the colour
// count are ever used. A result that is not taken holds in the output
// register while the next item is accepted and worked on; only that item's
// own result waits until the register frees.
module palette_builder_pixel_encoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_alpha,
  input  logic [7:0] in_entry_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte0,
  output logic [7:0] out_byte1,
  output logic [7:0] out_byte2,
  output logic [1:0] out_byte_count,
  output logic [8:0] out_palette_count,
  output logic       out_palette_used,
  output logic       out_transparency_seen,
  output logic       out_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data
);
  import pbpe_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SRCH  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_MOVE  = 7'b0001000,
    S_SWAP0 = 7'b0010000,
    S_SWAP1 = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] chan_r;
  logic       ten_r;
  logic [8:0] count_r, count_nxt;
  logic       ovf_r, ovf_nxt, trans_r, trans_nxt, fin_r, fin_nxt, kept_r, kept_nxt;
  logic [2:0] cmd_r;
  logic [23:0] col_r;
  logic       transp_px_r;
  logic [7:0] idx_r;
  // search pointer: ptr_r is the address issued; rv_r marks data valid for rptr_r
  logic [8:0] ptr_r, ptr_nxt;
  logic [7:0] rptr_r;
  logic       rv_r, rv_nxt;
  logic [12:0] dist_r, dist_nxt;
  logic [7:0] best_r, best_nxt;
  logic [PAL_W-1:0] hold_r, hold_nxt;
  logic       found_r, found_nxt;
  logic [7:0] fidx_r, fidx_nxt;
  logic       ov_r;
  logic [7:0] ob0_r, ob1_r, ob2_r;
  logic [1:0] ocnt_r;
  logic       ost_r;
  logic [8:0] opc_r;
  logic       oused_r, otr_r;
  logic       ov_set;
  logic [7:0] b0, b1, b2;
  logic [1:0] bc;
  logic       st;

  logic       we;
  logic [7:0] waddr, raddr;
  logic [PAL_W-1:0] wdata, rdata;

  pbpe_ram #(.WIDTH(PAL_W), .DEPTH(PAL_DEPTH)) u_pal (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic grey, alpha_on, used, take;
  assign grey     = (chan_r <= 3'd2);
  assign alpha_on = ten_r && !chan_r[0];
  assign used     = fin_r && kept_r;
  assign take     = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= 3'd4;
      ten_r  <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_CHAN) chan_r <= cfg_data;
      else ten_r <= cfg_data[0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r; ovf_nxt = ovf_r; trans_nxt = trans_r;
    fin_nxt = fin_r; kept_nxt = kept_r;
    ptr_nxt = ptr_r; rv_nxt = 1'b0;
    dist_nxt = dist_r; best_nxt = best_r; hold_nxt = hold_r;
    found_nxt = found_r; fidx_nxt = fidx_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = ptr_r[7:0];
    ov_set = 1'b0; b0 = '0; b1 = '0; b2 = '0; bc = '0; st = 1'b0;
    case (state_r)
      S_IDLE: begin
        raddr = in_entry_index;
        if (take) begin
          ptr_nxt = '0; found_nxt = 1'b0; dist_nxt = DIST_INIT; best_nxt = '0;
          case (in_cmd)
            CMD_SCAN: begin
              if (fin_r || ovf_r) state_nxt = S_DONE;
              else if (alpha_on && !in_alpha[7]) begin
                trans_nxt = 1'b1; state_nxt = S_DONE;
              end else if (grey) state_nxt = S_DONE;
              else state_nxt = S_SRCH;
            end
            CMD_FIN: begin
              if (fin_r) state_nxt = S_DONE;
              else begin
                fin_nxt = 1'b1;
                if (grey || ovf_r) begin
                  kept_nxt = 1'b0; count_nxt = '0; state_nxt = S_DONE;
                end else begin
                  kept_nxt = 1'b1;
                  if (!trans_r) state_nxt = S_DONE;
                  else if (count_r == 9'd0) begin
                    we = 1'b1; waddr = '0; wdata = RESERVED_MARK;
                    count_nxt = 9'd1; state_nxt = S_DONE;
                  end else if (count_r < 9'(PAL_DEPTH)) state_nxt = S_MOVE;
                  else state_nxt = S_SRCH;
                end
              end
              raddr = '0;
            end
            CMD_ENC: begin
              if (!grey && !(trans_r && !in_alpha[7]) && used) state_nxt = S_SRCH;
              else state_nxt = S_DONE;
            end
            CMD_READ: state_nxt = S_READ;
            CMD_CLR: begin
              count_nxt = '0; ovf_nxt = 1'b0; trans_nxt = 1'b0;
              fin_nxt = 1'b0; kept_nxt = 1'b0; state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SRCH: begin
        // issue addresses one per cycle; compare the data in the cycle after
        if (ptr_r < count_r && !found_r) begin
          ptr_nxt = ptr_r + 9'd1; rv_nxt = 1'b1;
        end
        if (rv_r) begin
          if (cmd_r == CMD_FIN) begin
            if (brightness(rdata) < dist_r) begin
              dist_nxt = brightness(rdata); best_nxt = rptr_r; hold_nxt = rdata;
            end
            if (rptr_r == 8'd0) fidx_nxt = rdata[7:0];
          end else if (rdata == {1'b0, col_r} && !found_r) begin
            found_nxt = 1'b1; fidx_nxt = rptr_r;
          end
        end
        if (!rv_r && (ptr_r >= count_r || found_r) && ptr_r != 9'd0 || count_r == 9'd0
            || (!rv_r && found_r)) begin
          if (cmd_r == CMD_FIN) state_nxt = S_SWAP0;
          else if (cmd_r == CMD_SCAN) begin
            if (!found_r) begin
              if (count_r >= 9'(PAL_DEPTH)) ovf_nxt = 1'b1;
              else begin
                we = 1'b1; waddr = count_r[7:0]; wdata = {1'b0, col_r};
                count_nxt = count_r + 9'd1;
              end
            end
            state_nxt = S_DONE;
          end else state_nxt = S_DONE;
        end
      end
      S_SWAP0: begin
        raddr = '0;
        state_nxt = S_SWAP1;
      end
      S_SWAP1: begin
        // rdata holds entry 0: put it at best, then best's colour at 0
        we = 1'b1; waddr = best_r; wdata = rdata;
        hold_nxt = hold_r;
        state_nxt = S_READ;
      end
      S_MOVE: begin
        // rdata holds entry 0, read in the accept cycle
        we = 1'b1; waddr = count_r[7:0]; wdata = rdata;
        hold_nxt = RESERVED_MARK;
        count_nxt = count_r + 9'd1;
        state_nxt = S_READ;
      end
      S_READ: begin
        // The requested entry is read here and shows on rdata in S_DONE.
        raddr = idx_r;
        if (cmd_r == CMD_FIN) begin
          we = 1'b1; waddr = '0; wdata = hold_r;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Keep the read address so rdata holds while the result waits.
        raddr = idx_r;
        if (!ov_r || !out_stall) begin
          ov_set = 1'b1;
          state_nxt = S_IDLE;
        end
        case (cmd_r)
          CMD_ENC: begin
            if (grey) begin
              b0 = col_r[23:16];
              if (trans_r) b0 = transp_px_r ? 8'd0 :
                                (col_r[23:16] == 8'd0 ? 8'd1 : col_r[23:16]);
              bc = 2'd1;
            end else if (trans_r && transp_px_r) bc = used ? 2'd1 : 2'd3;
            else if (used) begin
              if (found_r) begin b0 = fidx_r; bc = 2'd1; end
              else st = 1'b1;
            end else begin
              b0 = col_r[23:16]; b1 = col_r[15:8]; b2 = col_r[7:0];
              if (trans_r && col_r == 24'd0) b2 = 8'd1;
              bc = 2'd3;
            end
          end
          CMD_READ: begin
            if ({1'b0, idx_r} < count_r) begin
              b0 = rdata[23:16]; b1 = rdata[15:8]; b2 = rdata[7:0]; bc = 2'd3;
            end else st = 1'b1;
          end
          default: ;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0; ovf_r <= 1'b0; trans_r <= 1'b0; fin_r <= 1'b0; kept_r <= 1'b0;
      ov_r <= 1'b0; rv_r <= 1'b0; found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt; ovf_r <= ovf_nxt; trans_r <= trans_nxt;
      fin_r <= fin_nxt; kept_r <= kept_nxt;
      rv_r <= rv_nxt; found_r <= found_nxt;
      if (ov_set) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt; rptr_r <= ptr_r[7:0];
    dist_r <= dist_nxt; best_r <= best_nxt; hold_r <= hold_nxt; fidx_r <= fidx_nxt;
    if (take) begin
      cmd_r <= in_cmd; col_r <= {in_red, in_green, in_blue};
      transp_px_r <= !in_alpha[7]; idx_r <= in_entry_index;
    end
    if (ov_set) begin
      ob0_r <= b0; ob1_r <= b1; ob2_r <= b2; ocnt_r <= bc; ost_r <= st;
      opc_r <= count_r; oused_r <= used; otr_r <= trans_r;
    end
  end

  assign out_valid = ov_r;
  assign out_byte0 = ob0_r;
  assign out_byte1 = ob1_r;
  assign out_byte2 = ob2_r;
  assign out_byte_count = ocnt_r;
  assign out_palette_count = opc_r;
  assign out_palette_used = oused_r;
  assign out_transparency_seen = otr_r;
  assign out_status = ost_r;
endmodule

@@ src/pbpe_ram.sv @@
// ----------------------------------------------------------------------------
// pbpe_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module pbpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ src/pbpe_checker.sv @@
// ----------------------------------------------------------------------------
// pbpe_checker
// Port-level checks for the palette builder and pixel encoder.
// ----------------------------------------------------------------------------
module pbpe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_byte_count,
  input logic [8:0] out_palette_count,
  input logic       out_status
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_palette_count <= 9'd256) else $error("count range");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_byte_count == 2'd0) else $error("status bytes");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("second item taken");
  a_no_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_byte_count != 2'd2 || !out_valid) else $error("bad byte count");
endmodule

bind palette_builder_pixel_encoder_top pbpe_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_byte_count, .out_palette_count, .out_status
);

@@ verif/palette_builder_pixel_encoder_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_builder_pixel_encoder_top_tb
// Drives palette build and encode sequences into the palette encoder, keeps
// a behavioral copy of the palette state, and compares every result beat
// field by field against the predicted one.
// ----------------------------------------------------------------------------
module palette_builder_pixel_encoder_top_tb;
  import pbpe_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  // One input beat and one result beat.
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] entry_index;
  } pixel_cmd_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] byte_count;
    logic [8:0] palette_count;
    logic       palette_used;
    logic       transparency_seen;
    logic       status;
  } encoded_t;

  // A directed row: the beat, plus an optional typed-in expectation.
  typedef struct packed {
    pixel_cmd_t beat;
    logic       has_known;
    encoded_t   known;
  } directed_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_cmd;
  logic [7:0] in_red, in_green, in_blue, in_alpha, in_entry_index;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte0, out_byte1, out_byte2;
  logic [1:0] out_byte_count;
  logic [8:0] out_palette_count;
  logic       out_palette_used, out_transparency_seen, out_status;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [2:0] cfg_data;

  palette_builder_pixel_encoder_top dut (.*);

  // Clock: 20 ns period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the block's state, updated in acceptance order.
  logic [24:0] shadow_palette [0:255];
  logic [8:0]  shadow_count;
  logic        shadow_overflow, shadow_transparent, shadow_finalized, shadow_kept;
  logic [2:0]  shadow_channels;
  logic        shadow_alpha_enable;

  encoded_t expected_results[$];
  int       error_count;
  int       idle_cycles;
  bit       timed_out;

  // Idle rates in percent for each side.
  int sender_idle_pct;
  int receiver_idle_pct;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic logic [12:0] shade_of(input logic [24:0] c);
    return 13'(c[23:16]) * 13'd4 + 13'(c[15:8]) * 13'd5 + 13'(c[7:0]) * 13'd3;
  endfunction

  function automatic int lookup_colour(input logic [24:0] c);
    for (int i = 0; i < int'(shadow_count) && i < 256; i++)
      if (shadow_palette[i] == c) return i;
    return -1;
  endfunction

  // Applies one beat to the shadow state and returns the result it causes.
  function automatic encoded_t encode_pixel(input pixel_cmd_t p);
    encoded_t    r;
    logic        grey, alpha_live, used;
    logic [24:0] c, t;
    logic [7:0]  b;
    int          k, best;
    logic [12:0] darkest, d;
    r = '0;
    grey = shadow_channels <= 3'd2;
    alpha_live = shadow_alpha_enable && !shadow_channels[0];
    used = shadow_finalized && shadow_kept;
    c = {1'b0, p.red, p.green, p.blue};
    case (p.cmd)
      CMD_SCAN: begin
        if (!shadow_finalized && !shadow_overflow) begin
          if (alpha_live && p.alpha < 8'd128) begin
            shadow_transparent = 1'b1;
          end else if (!grey && lookup_colour(c) < 0) begin
            if (shadow_count >= 9'd256) begin
              shadow_overflow = 1'b1;
            end else begin
              shadow_palette[shadow_count[7:0]] = c;
              shadow_count++;
            end
          end
        end
      end
      CMD_FIN: begin
        if (!shadow_finalized) begin
          shadow_finalized = 1'b1;
          if (grey || shadow_overflow) begin
            shadow_kept = 1'b0;
            shadow_count = '0;
          end else begin
            shadow_kept = 1'b1;
            if (shadow_transparent) begin
              if (shadow_count == 9'd0) begin
                shadow_palette[0] = RESERVED_MARK;
                shadow_count = 9'd1;
              end else if (shadow_count < 9'd256) begin
                shadow_palette[shadow_count[7:0]] = shadow_palette[0];
                shadow_palette[0] = RESERVED_MARK;
                shadow_count++;
              end else begin
                // Full palette: pull the darkest entry, first minimum, to slot 0.
                best = 0;
                darkest = 13'h1fff;
                for (int i = 0; i < 256; i++) begin
                  d = shade_of(shadow_palette[i]);
                  if (d < darkest) begin
                    best = i;
                    darkest = d;
                  end
                end
                t = shadow_palette[best];
                shadow_palette[best] = shadow_palette[0];
                shadow_palette[0] = t;
              end
            end
          end
        end
      end
      CMD_ENC: begin
        if (grey) begin
          r.byte0 = p.red;
          if (shadow_transparent)
            r.byte0 = (p.alpha < 8'd128) ? 8'd0 : (p.red == 8'd0 ? 8'd1 : p.red);
          r.byte_count = 2'd1;
        end else if (shadow_transparent && p.alpha < 8'd128) begin
          r.byte_count = used ? 2'd1 : 2'd3;
        end else if (used) begin
          k = lookup_colour(c);
          if (k < 0) begin
            r.status = 1'b1;
          end else begin
            r.byte0 = 8'(k);
            r.byte_count = 2'd1;
          end
        end else begin
          b = p.blue;
          if (shadow_transparent && c == '0) b = 8'd1;
          r.byte0 = p.red;
          r.byte1 = p.green;
          r.byte2 = b;
          r.byte_count = 2'd3;
        end
      end
      CMD_READ: begin
        if (9'(p.entry_index) < shadow_count) begin
          t = shadow_palette[p.entry_index];
          r.byte0 = t[23:16];
          r.byte1 = t[15:8];
          r.byte2 = t[7:0];
          r.byte_count = 2'd3;
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_CLR: begin
        shadow_count = '0;
        shadow_overflow = 1'b0;
        shadow_transparent = 1'b0;
        shadow_finalized = 1'b0;
        shadow_kept = 1'b0;
      end
      default: ;
    endcase
    r.palette_count = shadow_count;
    r.palette_used = shadow_finalized && shadow_kept;
    r.transparency_seen = shadow_transparent;
    return r;
  endfunction

  // Receiver: random stall, checking at the rising edge.
  initial out_stall = 1'b1;
  always @(negedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  always @(posedge clk) begin
    encoded_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_byte0, out_byte1, out_byte2, out_byte_count, out_palette_count,
              out_palette_used, out_transparency_seen, out_status};
      if (expected_results.size() == 0) begin
        $display("[%0t] result beat with nothing expected", $realtime);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.byte0 != want.byte0) report_mismatch("byte0", got.byte0, want.byte0);
        if (got.byte1 != want.byte1) report_mismatch("byte1", got.byte1, want.byte1);
        if (got.byte2 != want.byte2) report_mismatch("byte2", got.byte2, want.byte2);
        if (got.byte_count != want.byte_count)
          report_mismatch("byte_count", got.byte_count, want.byte_count);
        if (got.palette_count != want.palette_count)
          report_mismatch("palette_count", got.palette_count, want.palette_count);
        if (got.palette_used != want.palette_used)
          report_mismatch("palette_used", got.palette_used, want.palette_used);
        if (got.transparency_seen != want.transparency_seen)
          report_mismatch("transparency_seen", got.transparency_seen,
                          want.transparency_seen);
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("palette_builder_pixel_encoder_top_tb: errors");
        $finish;
      end
    end
  end

  // Sends one input beat, idling beforehand at the sender's rate. The beat is
  // queued in the predictor at the edge that accepts it. Valid is left high on
  // return; the next beat replaces it or idles it low, or the drain takes it down.
  task automatic send_beat(input pixel_cmd_t p, input logic has_known, input encoded_t known);
    encoded_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= p.cmd;
    in_red <= p.red;
    in_green <= p.green;
    in_blue <= p.blue;
    in_alpha <= p.alpha;
    in_entry_index <= p.entry_index;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = encode_pixel(p);
    if (has_known && predicted != known) begin
      $display("[%0t] directed row disagrees with prediction", $realtime);
      error_count++;
    end
    expected_results.push_back(has_known ? known : predicted);
    @(negedge clk);
  endtask

  // Waits until every expected result has come, then lets the block settle.
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Writes one configuration register; only called with the block drained.
  task automatic write_register(input logic idx, input logic [2:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_CHAN) shadow_channels = value;
    else shadow_alpha_enable = value[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic pixel_cmd_t make_beat(input logic [2:0] cmd, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b,
                                           input logic [7:0] a, input logic [7:0] idx);
    return '{cmd, r, g, b, a, idx};
  endfunction

  // Random pixel, drawn mostly from a small colour set when spread is nonzero, so that repeats and hits happen.
  function automatic pixel_cmd_t random_pixel(input logic [2:0] cmd, input int spread);
    pixel_cmd_t p;
    p = make_beat(cmd, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
    if (spread > 0 && $urandom_range(3) != 0) begin
      p.red = 8'($urandom_range(spread));
      p.green = 8'($urandom_range(1));
      p.blue = 8'($urandom_range(1) * 255);
    end
    if ($urandom_range(3) == 0) {p.red, p.green, p.blue} = '0;
    if ($urandom_range(3) == 0) p.alpha = 8'($urandom_range(127));
    return p;
  endfunction

  // One frame: clear, scan some pixels, usually finalize, then encode, read and send random commands.
  task automatic run_frame(input int scans, input int spread, input int encodes);
    send_beat(make_beat(CMD_CLR, 0, 0, 0, 0, 0), 1'b0, '0);
    for (int i = 0; i < scans; i++) send_beat(random_pixel(CMD_SCAN, spread), 1'b0, '0);
    if ($urandom_range(7) != 0) send_beat(make_beat(CMD_FIN, 0, 0, 0, 0, 0), 1'b0, '0);
    if ($urandom_range(3) == 0) send_beat(make_beat(CMD_FIN, 0, 0, 0, 0, 0), 1'b0, '0);
    for (int i = 0; i < encodes; i++) begin
      case ($urandom_range(9))
        0, 1:    send_beat(make_beat(CMD_READ, 0, 0, 0, 0,
                                     8'($urandom_range(int'(shadow_count) + 2))), 1'b0, '0);
        2:       send_beat(random_pixel(3'($urandom_range(7)), spread), 1'b0, '0);
        default: send_beat(random_pixel(CMD_ENC, spread), 1'b0, '0);
      endcase
    end
  endtask

  // Directed table: extremes, each command and the named special cases.
  // Typed-in expectations are for rows whose outcome is obvious.
  directed_row_t directed_rows[] = '{
    '{make_beat(CMD_READ, 0, 0, 0, 0, 0),          1'b1, '{0, 0, 0, 0, 0, 0, 0, 1}},
    '{make_beat(CMD_ENC, 255, 255, 255, 255, 255), 1'b1, '{255, 255, 255, 3, 0, 0, 0, 0}},
    '{make_beat(CMD_ENC, 0, 0, 0, 0, 0),           1'b1, '{0, 0, 0, 3, 0, 0, 0, 0}},
    '{make_beat(3'd7, 255, 255, 255, 255, 255),    1'b1, '{0, 0, 0, 0, 0, 0, 0, 0}},
    '{make_beat(3'd5, 0, 0, 0, 0, 0),              1'b0, '0},
    '{make_beat(CMD_SCAN, 255, 255, 255, 255, 0),  1'b1, '{0, 0, 0, 0, 1, 0, 0, 0}},
    '{make_beat(CMD_SCAN, 0, 0, 0, 0, 0),          1'b1, '{0, 0, 0, 0, 2, 0, 0, 0}},
    '{make_beat(CMD_SCAN, 255, 255, 255, 0, 0),    1'b0, '0},
    '{make_beat(CMD_READ, 0, 0, 0, 0, 1),          1'b1, '{0, 0, 0, 3, 2, 0, 0, 0}},
    '{make_beat(CMD_READ, 0, 0, 0, 0, 255),        1'b1, '{0, 0, 0, 0, 2, 0, 0, 1}},
    '{make_beat(CMD_ENC, 0, 0, 0, 255, 0),         1'b0, '0},
    '{make_beat(CMD_FIN, 0, 0, 0, 0, 0),           1'b1, '{0, 0, 0, 0, 2, 1, 0, 0}},
    '{make_beat(CMD_FIN, 0, 0, 0, 0, 0),           1'b0, '0},
    '{make_beat(CMD_SCAN, 18, 52, 86, 255, 0),     1'b0, '0},
    '{make_beat(CMD_ENC, 255, 255, 255, 128, 0),   1'b1, '{0, 0, 0, 1, 2, 1, 0, 0}},
    '{make_beat(CMD_ENC, 1, 2, 3, 255, 0),         1'b1, '{0, 0, 0, 0, 2, 1, 0, 1}},
    '{make_beat(CMD_CLR, 0, 0, 0, 0, 0),           1'b1, '{0, 0, 0, 0, 0, 0, 0, 0}}
  };

  int frame_items;

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_SCAN;
    {in_red, in_green, in_blue, in_alpha, in_entry_index} = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CHAN;
    cfg_data = 3'd0;
    error_count = 0;
    sender_idle_pct = 19;
    receiver_idle_pct = 75;
    shadow_count = '0;
    shadow_overflow = 1'b0;
    shadow_transparent = 1'b0;
    shadow_finalized = 1'b0;
    shadow_kept = 1'b0;
    shadow_channels = 3'd4;
    shadow_alpha_enable = 1'b0;
    foreach (shadow_palette[i]) shadow_palette[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows run in the reset setting: rgba with alpha ignored.
    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].has_known, directed_rows[i].known);
    drain();

    // Transparency with an empty palette makes entry 0 the reserved slot,
    // then grey mode with transparency turns grey 0 into 1.
    write_register(CFG_TEN, 3'd1);
    send_beat(make_beat(CMD_SCAN, 9, 9, 9, 0, 0), 1'b0, '0);
    send_beat(make_beat(CMD_FIN, 0, 0, 0, 0, 0), 1'b0, '0);
    send_beat(make_beat(CMD_READ, 0, 0, 0, 0, 0), 1'b1, '{0, 0, 0, 3, 1, 1, 1, 0});
    send_beat(make_beat(CMD_ENC, 0, 0, 0, 0, 0), 1'b0, '0);
    drain();
    write_register(CFG_CHAN, 3'd2);
    send_beat(make_beat(CMD_SCAN, 0, 0, 0, 5, 0), 1'b0, '0);
    send_beat(make_beat(CMD_ENC, 0, 0, 0, 255, 0), 1'b0, '0);
    send_beat(make_beat(CMD_FIN, 0, 0, 0, 0, 0), 1'b0, '0);
    send_beat(make_beat(CMD_CLR, 0, 0, 0, 0, 0), 1'b0, '0);
    drain();

    // Full palette with transparency: darkest entry moves to slot 0; after a clear,
    // a 257th new colour overflows. Run once in rgba with alpha honored.
    write_register(CFG_CHAN, 3'd4);
    for (int i = 0; i < 256; i++)
      send_beat(make_beat(CMD_SCAN, 8'(i + 7), 8'(255 - i), 8'(i * 3), 255, 0), 1'b0, '0);
    send_beat(make_beat(CMD_SCAN, 1, 1, 1, 0, 0), 1'b0, '0);
    send_beat(make_beat(CMD_FIN, 0, 0, 0, 0, 0), 1'b0, '0);
    for (int i = 0; i < 6; i++)
      send_beat(make_beat(CMD_READ, 0, 0, 0, 0, 8'($urandom_range(255))), 1'b0, '0);
    send_beat(make_beat(CMD_ENC, 7, 255, 0, 200, 0), 1'b0, '0);
    send_beat(make_beat(CMD_CLR, 0, 0, 0, 0, 0), 1'b0, '0);
    for (int i = 0; i < 257; i++)
      send_beat(make_beat(CMD_SCAN, 8'(i), 8'(i >> 8), 8'd4, 255, 0), 1'b0, '0);
    send_beat(make_beat(CMD_FIN, 0, 0, 0, 0, 0), 1'b0, '0);
    send_beat(make_beat(CMD_ENC, 0, 0, 0, 255, 0), 1'b0, '0);

    // Random frames across settings and the three idling phases. The sender
    // also holds off until the block has drained before each setting change.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 75 : 0;
      receiver_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 19 : 0;
      frame_items = 0;
      while (frame_items < 200) begin
        drain();
        write_register(CFG_CHAN, 3'($urandom_range(7)));
        write_register(CFG_TEN, 3'($urandom_range(1)));
        begin
          int scans, encodes;
          scans = $urandom_range(30);
          encodes = $urandom_range(20);
          run_frame(scans, ($urandom_range(1) == 1) ? 15 : 0, encodes);
          frame_items += scans + encodes + 2;
        end
      end
    end
    drain();
    write_register(CFG_CHAN, 3'd7);
    write_register(CFG_TEN, 3'd0);
    run_frame(12, 3, 12);
    drain();

    if (error_count == 0) begin
      $display("palette_builder_pixel_encoder_top_tb: clean");
    end else begin
      $display("palette_builder_pixel_encoder_top_tb: errors");
    end
    $finish;
  end
endmodule

@@ files.f @@
src/pbpe_pkg.sv
src/pbpe_ram.sv
src/palette_builder_pixel_encoder_top.sv
src/pbpe_checker.sv
verif/palette_builder_pixel_encoder_top_tb.sv
